/* src/mfc_pkg.sv */
// Shared types, constants and helpers of the motion fault classifier.
package mfc_pkg;

  // Field widths.
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 16;
  localparam int THRESH_W   = 15;
  localparam int DWELL_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MIN_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_SPEED      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATIONARY_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_DWELL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_DWELL    = 3'd4;

  // Register values after reset.
  localparam logic [THRESH_W-1:0] RST_COMMAND_MIN_SPEED = 15'd100;
  localparam logic [THRESH_W-1:0] RST_MOVING_SPEED      = 15'd50;
  localparam logic [THRESH_W-1:0] RST_STATIONARY_SPEED  = 15'd10;
  localparam logic [DWELL_W-1:0]  RST_FAULT_DWELL       = 20'd500;
  localparam logic [DWELL_W-1:0]  RST_RECOVERY_DWELL    = 20'd1000;

  // Queue between the classifier and the fault tracker.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result queue at the output.
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_SLIP    = 2'd1,
    FAULT_STALL   = 2'd2,
    FAULT_ENCODER = 2'd3
  } fault_t;

  // Speed thresholds used by the classifier.
  typedef struct packed {
    logic [THRESH_W-1:0] command_min_speed;
    logic [THRESH_W-1:0] moving_speed;
    logic [THRESH_W-1:0] stationary_speed;
  } thresh_t;

  // Dwell times used by the fault tracker.
  typedef struct packed {
    logic [DWELL_W-1:0] fault_dwell_ms;
    logic [DWELL_W-1:0] recovery_dwell_ms;
  } dwell_t;

  // One classified sample.
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    fault_t            obs;
  } obs_word_t;

  // Magnitude of a two's complement speed; the most negative value gives 32768.
  function automatic logic [SPEED_W-1:0] speed_mag(input logic [SPEED_W-1:0] v);
    logic [SPEED_W-1:0] neg;
    neg = ~v + {{(SPEED_W-1){1'b0}}, 1'b1};
    return v[SPEED_W-1] ? neg : v;
  endfunction

endpackage

/* src/motion_fault_classifier.sv */
// Top level of the motion fault classifier: registers and the three parts.
//
//   Channel   Handshake             Payload
//   in_       in_push / in_full     time, three speeds, three valid flags
//   out_      out_pop / out_empty   active fault code
//   cfg_      cfg_valid / cfg_ready register index and data
//
// One word is taken per cycle while in_full is low. A result reaches the
// output ports through the front holding register, the middle queue and the
// result queue. Reset empties both queues, clears the timers and loads the
// register defaults. A stalled output fills the result queue, then the middle
// queue, then the holding register, and only then raises in_full.
module motion_fault_classifier
  import mfc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [TIME_W-1:0]         in_time_ms,
  input  logic signed [SPEED_W-1:0] in_command_speed,
  input  logic signed [SPEED_W-1:0] in_wheel_speed,
  input  logic signed [SPEED_W-1:0] in_visual_speed,
  input  logic                      in_command_ok,
  input  logic                      in_wheel_ok,
  input  logic                      in_visual_ok,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [1:0]                out_active_fault,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  thresh_t   thr_r;
  dwell_t    dw_r;
  logic      cfg_write;
  logic      f_valid, q_ready, q_valid, q_pop;
  obs_word_t f_word, q_word;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.command_min_speed <= RST_COMMAND_MIN_SPEED;
      thr_r.moving_speed      <= RST_MOVING_SPEED;
      thr_r.stationary_speed  <= RST_STATIONARY_SPEED;
      dw_r.fault_dwell_ms     <= RST_FAULT_DWELL;
      dw_r.recovery_dwell_ms  <= RST_RECOVERY_DWELL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COMMAND_MIN_SPEED: thr_r.command_min_speed <= cfg_data[THRESH_W-1:0];
        REG_MOVING_SPEED:      thr_r.moving_speed      <= cfg_data[THRESH_W-1:0];
        REG_STATIONARY_SPEED:  thr_r.stationary_speed  <= cfg_data[THRESH_W-1:0];
        REG_FAULT_DWELL:       dw_r.fault_dwell_ms     <= cfg_data[DWELL_W-1:0];
        REG_RECOVERY_DWELL:    dw_r.recovery_dwell_ms  <= cfg_data[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  mfc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .thr              (thr_r),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_time_ms       (in_time_ms),
    .in_command_speed (in_command_speed),
    .in_wheel_speed   (in_wheel_speed),
    .in_visual_speed  (in_visual_speed),
    .in_command_ok    (in_command_ok),
    .in_wheel_ok      (in_wheel_ok),
    .in_visual_ok     (in_visual_ok),
    .word_valid       (f_valid),
    .word             (f_word),
    .word_ready       (q_ready)
  );

  mfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_word  (f_word),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_word   (q_word)
  );

  mfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .dw               (dw_r),
    .word_valid       (q_valid),
    .word             (q_word),
    .word_pop         (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_active_fault (out_active_fault)
  );

endmodule

/* src/mfc_front.sv */
// Front end: takes a sample, classifies it and holds the word for the queue.
module mfc_front
  import mfc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  thresh_t                   thr,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [TIME_W-1:0]         in_time_ms,
  input  logic signed [SPEED_W-1:0] in_command_speed,
  input  logic signed [SPEED_W-1:0] in_wheel_speed,
  input  logic signed [SPEED_W-1:0] in_visual_speed,
  input  logic                      in_command_ok,
  input  logic                      in_wheel_ok,
  input  logic                      in_visual_ok,
  output logic                      word_valid,
  output obs_word_t                 word,
  input  logic                      word_ready
);

  logic               valid_r, valid_nxt;
  obs_word_t          word_r;
  fault_t             obs;
  logic               accept;
  logic [SPEED_W-1:0] cmd_mag, wh_mag, vis_mag;
  logic [SPEED_W-1:0] min_ext, mov_ext, still_ext;
  logic               wh_moving, vis_moving, wh_still, vis_still;

  // Classify the incoming sample on its own.
  always_comb begin
    cmd_mag    = speed_mag(in_command_speed);
    wh_mag     = speed_mag(in_wheel_speed);
    vis_mag    = speed_mag(in_visual_speed);
    min_ext    = {1'b0, thr.command_min_speed};
    mov_ext    = {1'b0, thr.moving_speed};
    still_ext  = {1'b0, thr.stationary_speed};
    wh_moving  = wh_mag >= mov_ext;
    vis_moving = vis_mag >= mov_ext;
    wh_still   = wh_mag <= still_ext;
    vis_still  = vis_mag <= still_ext;
    obs        = FAULT_NONE;
    if (in_command_ok && in_wheel_ok && in_visual_ok && cmd_mag >= min_ext) begin
      if (wh_moving && vis_still) begin
        obs = FAULT_SLIP;
      end else if (wh_still && vis_still) begin
        obs = FAULT_STALL;
      end else if (wh_still && vis_moving) begin
        obs = FAULT_ENCODER;
      end
    end
  end

  // The holding register takes a new word whenever it is empty or draining.
  assign in_full   = valid_r && !word_ready;
  assign accept    = in_push && !in_full;
  assign valid_nxt = accept || (valid_r && !word_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r.time_ms <= in_time_ms;
      word_r.obs     <= obs;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

/* src/mfc_queue.sv */
// Short queue of classified words between the front end and the tracker.
module mfc_queue
  import mfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  obs_word_t push_word,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output obs_word_t pop_word
);

  obs_word_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign push_ready = cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_word   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* src/mfc_back.sv */
// Back end: fault and recovery timers, and the result queue.
module mfc_back
  import mfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dwell_t     dw,
  input  logic       word_valid,
  input  obs_word_t  word,
  output logic       word_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [1:0] out_active_fault
);

  fault_t                fault_now_r, fault_now_nxt;
  fault_t                pend_fault_r, pend_fault_nxt;
  logic                  pend_armed_r, pend_armed_nxt;
  logic [TIME_W-1:0]     pend_start_r, pend_start_nxt;
  logic                  clr_armed_r, clr_armed_nxt;
  logic [TIME_W-1:0]     clr_start_r, clr_start_nxt;

  fault_t                res_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  res_wr_r, res_rd_r;
  logic [OUT_CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic                  res_take, room;

  logic [TIME_W-1:0]     t;
  fault_t                obs;
  logic                  pend_early, clr_early;
  logic                  pend_done, clr_done;
  logic [TIME_W-1:0]     pend_elapsed, clr_elapsed;

  // Result queue handshake; a pop in the same cycle frees a slot.
  assign out_empty        = res_cnt_r == '0;
  assign res_take         = out_pop && !out_empty;
  assign room             = (res_cnt_r != OUT_CNT_W'(OUT_DEPTH)) || res_take;
  assign word_pop         = word_valid && room;
  assign out_active_fault = res_r[res_rd_r];

  // Timer comparisons against the current sample time.
  always_comb begin
    t            = word.time_ms;
    obs          = word.obs;
    pend_early   = t < pend_start_r;
    clr_early    = t < clr_start_r;
    pend_elapsed = t - pend_start_r;
    clr_elapsed  = t - clr_start_r;
    pend_done    = pend_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, dw.fault_dwell_ms};
    clr_done     = clr_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, dw.recovery_dwell_ms};
  end

  // State update for one word.
  always_comb begin
    fault_now_nxt  = fault_now_r;
    pend_fault_nxt = pend_fault_r;
    pend_armed_nxt = pend_armed_r;
    pend_start_nxt = pend_start_r;
    clr_armed_nxt  = clr_armed_r;
    clr_start_nxt  = clr_start_r;
    if (fault_now_r == FAULT_NONE || (obs != fault_now_r && obs != FAULT_NONE)) begin
      clr_armed_nxt = 1'b0;
      if (obs == FAULT_NONE) begin
        pend_armed_nxt = 1'b0;
      end else if (!pend_armed_r || pend_fault_r != obs || pend_early) begin
        // New or changed candidate, or time went backwards: restart the timer.
        pend_fault_nxt = obs;
        pend_start_nxt = t;
        pend_armed_nxt = 1'b1;
      end else if (pend_done) begin
        fault_now_nxt  = obs;
        pend_armed_nxt = 1'b0;
      end
    end else if (obs == fault_now_r) begin
      clr_armed_nxt  = 1'b0;
      pend_armed_nxt = 1'b0;
    end else begin
      // Active fault, nothing observed: run the recovery timer.
      pend_armed_nxt = 1'b0;
      if (!clr_armed_r || clr_early) begin
        clr_start_nxt = t;
        clr_armed_nxt = 1'b1;
      end else if (clr_done) begin
        fault_now_nxt = FAULT_NONE;
        clr_armed_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (word_pop && !res_take) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (res_take && !word_pop) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_now_r  <= FAULT_NONE;
      pend_fault_r <= FAULT_NONE;
      pend_armed_r <= 1'b0;
      pend_start_r <= '0;
      clr_armed_r  <= 1'b0;
      clr_start_r  <= '0;
      res_wr_r     <= '0;
      res_rd_r     <= '0;
      res_cnt_r    <= '0;
    end else begin
      if (word_pop) begin
        fault_now_r  <= fault_now_nxt;
        pend_fault_r <= pend_fault_nxt;
        pend_armed_r <= pend_armed_nxt;
        pend_start_r <= pend_start_nxt;
        clr_armed_r  <= clr_armed_nxt;
        clr_start_r  <= clr_start_nxt;
        res_wr_r     <= res_wr_r + 1'b1;
      end
      if (res_take) begin
        res_rd_r <= res_rd_r + 1'b1;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (word_pop) begin
      res_r[res_wr_r] <= fault_now_nxt;
    end
  end

endmodule

/* src/mfc_checker.sv */
// Port-level checks of the motion fault classifier, bound to the top level.
module mfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_pop,
  input logic       out_empty,
  input logic [1:0] out_active_fault
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> out_empty)
    else $error("result shown right after reset");

  // Reset leaves room for a new word.
  a_reset_not_full: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_full)
    else $error("input full right after reset");

  // A waiting result that is not taken stays as it is.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_active_fault)))
    else $error("waiting result changed or vanished");

endmodule

bind motion_fault_classifier mfc_checker u_mfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_pop          (out_pop),
  .out_empty        (out_empty),
  .out_active_fault (out_active_fault)
);

/* bench/tb_motion_fault_classifier.sv */
// Self-checking testbench for the motion fault classifier, with its own fault tracking predictor.
`timescale 1ns / 1ps

module tb_motion_fault_classifier
  import mfc_pkg::*;
();

  localparam int PIPE_LATENCY = 2;
  localparam int WORDS_PER_PHASE = 270;
  localparam int PHASES = 6;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [2:0] ALL_OK = 3'b111;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {MAG_STILL, MAG_MOVING, MAG_NEAR, MAG_ANY} mag_kind_t;

  typedef struct {
    logic [TIME_W-1:0]  time_ms;
    logic [SPEED_W-1:0] command_speed;
    logic [SPEED_W-1:0] wheel_speed;
    logic [SPEED_W-1:0] visual_speed;
    logic               command_ok;
    logic               wheel_ok;
    logic               visual_ok;
  } sample_t;

  typedef struct {
    sample_t s;
    bit      typed;
    fault_t  fault;
  } directed_row_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // Clock and the block's inputs, all known from time zero.
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic [TIME_W-1:0]         in_time_ms = '0;
  logic signed [SPEED_W-1:0] in_command_speed = '0;
  logic signed [SPEED_W-1:0] in_wheel_speed = '0;
  logic signed [SPEED_W-1:0] in_visual_speed = '0;
  logic                      in_command_ok = 1'b0;
  logic                      in_wheel_ok = 1'b0;
  logic                      in_visual_ok = 1'b0;
  logic                      out_pop = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_full;
  logic                      out_empty;
  logic [1:0]                out_active_fault;
  logic                      cfg_ready;

  // Predictor copy of the registers and of the tracker state.
  logic [THRESH_W-1:0] cmd_min = RST_COMMAND_MIN_SPEED;
  logic [THRESH_W-1:0] moving_thr = RST_MOVING_SPEED;
  logic [THRESH_W-1:0] still_thr = RST_STATIONARY_SPEED;
  logic [DWELL_W-1:0]  fault_dwell = RST_FAULT_DWELL;
  logic [DWELL_W-1:0]  recovery_dwell = RST_RECOVERY_DWELL;
  fault_t              cur_fault = FAULT_NONE;
  fault_t              cand_fault = FAULT_NONE;
  logic                cand_armed = 1'b0;
  logic [TIME_W-1:0]   cand_start = '0;
  logic                clear_armed = 1'b0;
  logic [TIME_W-1:0]   clear_start = '0;

  fault_t        expected_faults[$];
  directed_row_t directed_rows[$];
  reg_write_t    reg_writes[$];
  int            mismatch_count = 0;
  int            fault_words = 0;
  int            push_idle_pct = 0;
  int            pop_stall_pct = 0;
  fault_t        want_fault;

  // Random stream state: running timestamp and the fault the sequence aims at.
  logic [TIME_W-1:0] sim_ms = '0;
  fault_t            target_fault = FAULT_NONE;
  int                run_left = 0;

  motion_fault_classifier u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_time_ms       (in_time_ms),
    .in_command_speed (in_command_speed),
    .in_wheel_speed   (in_wheel_speed),
    .in_visual_speed  (in_visual_speed),
    .in_command_ok    (in_command_ok),
    .in_wheel_ok      (in_wheel_ok),
    .in_visual_ok     (in_visual_ok),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_active_fault (out_active_fault),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude as 17 bits, so that the most negative speed gives 32768.
  function automatic logic [16:0] speed_magnitude(input logic [SPEED_W-1:0] v);
    if (v[SPEED_W-1]) begin
      return 17'h10000 - {1'b0, v};
    end
    return {1'b0, v};
  endfunction

  // Judge one sample on its own against the speed thresholds.
  function automatic fault_t classify(input sample_t s);
    logic [16:0] cmd_mag;
    logic [16:0] wh_mag;
    logic [16:0] vis_mag;
    logic        wh_moving;
    logic        vis_moving;
    logic        wh_still;
    logic        vis_still;
    cmd_mag = speed_magnitude(s.command_speed);
    wh_mag = speed_magnitude(s.wheel_speed);
    vis_mag = speed_magnitude(s.visual_speed);
    if (!(s.command_ok && s.wheel_ok && s.visual_ok) || cmd_mag < {2'b00, cmd_min}) begin
      return FAULT_NONE;
    end
    wh_moving = wh_mag >= {2'b00, moving_thr};
    vis_moving = vis_mag >= {2'b00, moving_thr};
    wh_still = wh_mag <= {2'b00, still_thr};
    vis_still = vis_mag <= {2'b00, still_thr};
    if (wh_moving && vis_still) begin
      return FAULT_SLIP;
    end
    if (wh_still && vis_still) begin
      return FAULT_STALL;
    end
    if (wh_still && vis_moving) begin
      return FAULT_ENCODER;
    end
    return FAULT_NONE;
  endfunction

  // A new, different or time-reversed candidate restarts its timer; one that
  // has lasted the fault dwell becomes the active fault.
  function automatic void follow_candidate(input fault_t seen, input logic [TIME_W-1:0] t);
    if (!cand_armed || cand_fault != seen || t < cand_start) begin
      cand_fault = seen;
      cand_start = t;
      cand_armed = 1'b1;
    end else if (32'(t - cand_start) >= {12'd0, fault_dwell}) begin
      cur_fault = seen;
      cand_armed = 1'b0;
    end
  endfunction

  // Move the tracker on by one sample and give the fault that it then reports.
  function automatic fault_t advance_fault_state(input sample_t s);
    fault_t seen;
    seen = classify(s);
    if (cur_fault == FAULT_NONE) begin
      clear_armed = 1'b0;
      if (seen == FAULT_NONE) begin
        cand_armed = 1'b0;
      end else begin
        follow_candidate(seen, s.time_ms);
      end
    end else if (seen == cur_fault) begin
      clear_armed = 1'b0;
      cand_armed = 1'b0;
    end else if (seen != FAULT_NONE) begin
      clear_armed = 1'b0;
      follow_candidate(seen, s.time_ms);
    end else begin
      cand_armed = 1'b0;
      if (!clear_armed || s.time_ms < clear_start) begin
        clear_start = s.time_ms;
        clear_armed = 1'b1;
      end else if (32'(s.time_ms - clear_start) >= {12'd0, recovery_dwell}) begin
        cur_fault = FAULT_NONE;
        clear_armed = 1'b0;
      end
    end
    return cur_fault;
  endfunction

  // Register write as the block sees it: spare indexes do nothing, high bits drop.
  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COMMAND_MIN_SPEED: cmd_min = data[THRESH_W-1:0];
      REG_MOVING_SPEED:      moving_thr = data[THRESH_W-1:0];
      REG_STATIONARY_SPEED:  still_thr = data[THRESH_W-1:0];
      REG_FAULT_DWELL:       fault_dwell = data[DWELL_W-1:0];
      REG_RECOVERY_DWELL:    recovery_dwell = data[DWELL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [TIME_W-1:0] t, input int cmd, input int wh,
                                  input int vis, input logic [2:0] oks, input bit typed,
                                  input fault_t fault);
    directed_row_t r;
    r.s.time_ms = t;
    r.s.command_speed = 16'(cmd);
    r.s.wheel_speed = 16'(wh);
    r.s.visual_speed = 16'(vis);
    {r.s.command_ok, r.s.wheel_ok, r.s.visual_ok} = oks;
    r.typed = typed;
    r.fault = fault;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.insert(reg_writes.size(), w);
  endfunction

  // Magnitude in 0..32768 of the requested kind, relative to the thresholds.
  function automatic int pick_mag(input mag_kind_t kind);
    int m;
    case (kind)
      MAG_STILL:  m = $urandom_range(0, int'(still_thr));
      MAG_MOVING: m = $urandom_range(int'(moving_thr), 32768);
      MAG_NEAR: begin
        case ($urandom_range(0, 5))
          0:       m = int'(still_thr);
          1:       m = int'(still_thr) + 1;
          2:       m = int'(moving_thr) - 1;
          3:       m = int'(moving_thr);
          4:       m = 0;
          default: m = 32768;
        endcase
      end
      default:    m = $urandom_range(0, 32768);
    endcase
    if (m < 0) begin
      m = 0;
    end
    return m;
  endfunction

  function automatic logic [SPEED_W-1:0] to_speed(input int mag);
    if (mag >= 32768) begin
      return 16'h8000;
    end
    if ($urandom_range(0, 1) == 1) begin
      return 16'(-mag);
    end
    return 16'(mag);
  endfunction

  // Runs of samples aimed at one fault, with time mostly moving forward in
  // steps scaled to the dwell times, plus some noise and broken timestamps.
  function automatic sample_t next_random_sample();
    sample_t   s;
    int        r;
    int        scale;
    int        cmd_mag;
    mag_kind_t wh_kind;
    mag_kind_t vis_kind;
    if (run_left == 0) begin
      target_fault = fault_t'($urandom_range(0, 3));
      run_left = $urandom_range(1, 12);
    end
    run_left--;
    scale = (int'(fault_dwell) + int'(recovery_dwell)) / 6 + 1;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      sim_ms = sim_ms - 32'($urandom_range(0, 4 * scale));
    end else if (r < 5) begin
      sim_ms = $urandom();
    end else begin
      sim_ms = sim_ms + 32'($urandom_range(0, scale));
    end
    s.time_ms = sim_ms;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      cmd_mag = (cmd_min == 0) ? 0 : $urandom_range(0, int'(cmd_min) - 1);
    end else if (r < 14) begin
      cmd_mag = (r < 11 && cmd_min != 0) ? int'(cmd_min) - 1 : int'(cmd_min);
    end else begin
      cmd_mag = $urandom_range(int'(cmd_min), 32768);
    end
    s.command_speed = to_speed(cmd_mag);
    case (target_fault)
      FAULT_SLIP: begin
        wh_kind = MAG_MOVING;
        vis_kind = MAG_STILL;
      end
      FAULT_STALL: begin
        wh_kind = MAG_STILL;
        vis_kind = MAG_STILL;
      end
      FAULT_ENCODER: begin
        wh_kind = MAG_STILL;
        vis_kind = MAG_MOVING;
      end
      default: begin
        wh_kind = MAG_ANY;
        vis_kind = MAG_ANY;
      end
    endcase
    if ($urandom_range(0, 99) < 15) begin
      wh_kind = MAG_NEAR;
    end
    if ($urandom_range(0, 99) < 15) begin
      vis_kind = MAG_NEAR;
    end
    s.wheel_speed = to_speed(pick_mag(wh_kind));
    s.visual_speed = to_speed(pick_mag(vis_kind));
    {s.command_ok, s.wheel_ok, s.visual_ok} = ALL_OK;
    // Noise: dropped valid flags or raw speeds.
    if ($urandom_range(0, 99) < 12) begin
      {s.command_ok, s.wheel_ok, s.visual_ok} = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) begin
        s.command_speed = 16'($urandom());
        s.wheel_speed = 16'($urandom());
        s.visual_speed = 16'($urandom());
      end
    end
    return s;
  endfunction

  // Offer one word, with idle cycles ahead of it, and log what it should give.
  task automatic send_sample(input sample_t s, input bit typed, input fault_t typed_fault);
    fault_t predicted;
    while ($urandom_range(0, 99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_time_ms <= s.time_ms;
    in_command_speed <= s.command_speed;
    in_wheel_speed <= s.wheel_speed;
    in_visual_speed <= s.visual_speed;
    in_command_ok <= s.command_ok;
    in_wheel_ok <= s.wheel_ok;
    in_visual_ok <= s.visual_ok;
    do @(posedge clk); while (in_full);
    predicted = advance_fault_state(s);
    expected_faults.insert(expected_faults.size(), typed ? typed_fault : predicted);
  endtask

  // Stop offering words and let every pending result drain out.
  task automatic quiesce();
    in_push <= 1'b0;
    while (expected_faults.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic apply_reg_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes[0];
      reg_writes.delete(0);
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      do @(posedge clk); while (!cfg_ready);
      set_reg(w.idx, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each popped word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      fault_words++;
      if (expected_faults.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("word %0d: fault %0d popped with nothing pending", fault_words,
                   out_active_fault);
        end
      end else begin
        want_fault = expected_faults[0];
        expected_faults.delete(0);
        if (out_active_fault !== want_fault) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("word %0d: active_fault expected %0d (%s), got %0d", fault_words,
                     want_fault, want_fault.name(), out_active_fault);
          end
        end
      end
    end
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  initial begin
    directed_row_t r;
    idle_mode_t    mode;
    int            vm;

    // Directed samples under the reset thresholds (100 / 50 / 10, dwells 500 / 1000).
    add_row(32'd0, 0, 0, 0, ALL_OK, 1'b1, FAULT_NONE);         // just after reset
    add_row(32'd10, 200, 100, 0, ALL_OK, 1'b0, FAULT_NONE);    // slip candidate
    add_row(32'd510, 200, 100, 0, ALL_OK, 1'b0, FAULT_NONE);   // slip after dwell
    add_row(32'd600, -32768, 0, 0, ALL_OK, 1'b0, FAULT_NONE);  // stall, most negative
    add_row(32'd700, -32767, -5, 32767, ALL_OK, 1'b0, FAULT_NONE); // encoder restarts
    add_row(32'd100, 200, 0, 100, ALL_OK, 1'b0, FAULT_NONE);   // time going backwards
    add_row(32'd600, 200, 0, 100, ALL_OK, 1'b0, FAULT_NONE);   // encoder after dwell
    add_row(32'd700, 200, 0, 100, 3'b101, 1'b0, FAULT_NONE);   // wheel flag low
    add_row(32'd1699, 200, 0, 100, 3'b011, 1'b0, FAULT_NONE);  // command flag low
    add_row(32'd1700, 200, 0, 100, 3'b110, 1'b0, FAULT_NONE);  // recovery complete
    add_row(32'd2000, 99, 100, 0, ALL_OK, 1'b1, FAULT_NONE);   // command just too slow
    add_row(32'd2001, 100, -32768, 32767, ALL_OK, 1'b1, FAULT_NONE); // both moving
    add_row(32'd2002, 100, 50, -10, ALL_OK, 1'b0, FAULT_NONE); // slip on the thresholds
    add_row(32'd2003, 100, 10, 50, ALL_OK, 1'b0, FAULT_NONE);  // encoder on the thresholds
    add_row(32'd2004, 100, 11, 49, ALL_OK, 1'b0, FAULT_NONE);  // between the thresholds
    add_row(32'hFFFF_FFFF, 32767, 0, 0, ALL_OK, 1'b0, FAULT_NONE); // latest timestamp
    add_row(32'd0, 32767, 0, 0, ALL_OK, 1'b0, FAULT_NONE);     // wrap back to zero
    add_row(32'd499, 32767, 0, 0, ALL_OK, 1'b0, FAULT_NONE);
    add_row(32'd500, 32767, 0, 0, ALL_OK, 1'b0, FAULT_NONE);   // stall after dwell
    add_row(32'd500, -100, 1, -1, ALL_OK, 1'b0, FAULT_NONE);   // stall held
    add_row(32'd600, 200, 0, 0, 3'b110, 1'b0, FAULT_NONE);     // recovery starts
    add_row(32'd5, 200, 0, 0, 3'b000, 1'b0, FAULT_NONE);       // recovery timer restarts
    add_row(32'd1005, 200, 0, 0, 3'b100, 1'b0, FAULT_NONE);    // recovery complete

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (directed_rows.size() != 0) begin
      r = directed_rows[0];
      directed_rows.delete(0);
      send_sample(r.s, r.typed, r.fault);
    end

    // Random phases; all but the first write their own registers; four idling patterns in turn.
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      case (p)
        1: begin
          add_write(REG_COMMAND_MIN_SPEED, 20'd1);
          add_write(REG_MOVING_SPEED, 20'd1);
          add_write(REG_STATIONARY_SPEED, 20'd0);
          add_write(REG_FAULT_DWELL, 20'd1);
          add_write(REG_RECOVERY_DWELL, 20'd1);
        end
        2: begin
          add_write(REG_COMMAND_MIN_SPEED, 20'd32767);
          add_write(REG_MOVING_SPEED, 20'd32767);
          add_write(REG_STATIONARY_SPEED, 20'd32767);
          add_write(REG_FAULT_DWELL, 20'd1000000);
          add_write(REG_RECOVERY_DWELL, 20'd1000000);
        end
        3: begin
          // High data bits dropped, spare indexes ignored, zero dwells, overlapping bands.
          add_write(REG_COMMAND_MIN_SPEED, 20'h08064);
          add_write(REG_MOVING_SPEED, 20'hF0032);
          add_write(REG_STATIONARY_SPEED, 20'd300);
          add_write(REG_SPARE_LO, 20'hFFFFF);
          add_write(REG_SPARE_HI, 20'd0);
          add_write(REG_FAULT_DWELL, 20'd0);
          add_write(REG_RECOVERY_DWELL, 20'd0);
        end
        4: begin
          vm = $urandom_range(1, 3000);
          add_write(REG_COMMAND_MIN_SPEED, 20'($urandom_range(1, 2000)));
          add_write(REG_MOVING_SPEED, 20'(vm));
          add_write(REG_STATIONARY_SPEED, 20'($urandom_range(0, vm)));
          add_write(REG_FAULT_DWELL, 20'($urandom_range(1, 5000)));
          add_write(REG_RECOVERY_DWELL, 20'($urandom_range(1, 5000)));
        end
        5: begin
          add_write(REG_COMMAND_MIN_SPEED, 20'd500);
          add_write(REG_MOVING_SPEED, 20'd100);
          add_write(REG_STATIONARY_SPEED, 20'd20);
          add_write(REG_FAULT_DWELL, 20'hFFFFF);
          add_write(REG_RECOVERY_DWELL, 20'hFFFFF);
        end
        default: ;
      endcase
      apply_reg_writes();

      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_SENDER: begin
          push_idle_pct = 57;
          pop_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          push_idle_pct = 0;
          pop_stall_pct = 57;
        end
        IDLE_BOTH: begin
          push_idle_pct = 35;
          pop_stall_pct = 35;
        end
        default: begin
          push_idle_pct = 0;
          pop_stall_pct = 0;
        end
      endcase

      sim_ms = $urandom();
      run_left = 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_sample(next_random_sample(), 1'b0, FAULT_NONE);
      end
    end

    // Drain, then keep watching for any stray result before the verdict.
    quiesce();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* motion_fault_classifier.f */
src/mfc_pkg.sv
src/mfc_front.sv
src/mfc_queue.sv
src/mfc_back.sv
src/motion_fault_classifier.sv
src/mfc_checker.sv
bench/tb_motion_fault_classifier.sv
